@@ hw/rtl/priority_rectangle_hit_test_top_assert.svh @@
// Assertion macros for the top-level RTL file, which checks itself.
// Each macro checks on the rising edge of clk and is off while arst_n is low.
`ifndef PRIORITY_RECTANGLE_HIT_TEST_TOP_ASSERT_SVH
`define PRIORITY_RECTANGLE_HIT_TEST_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRHT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prht same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prht next-cycle check failed");

`endif

@@ hw/rtl/prht_pkg.sv @@
package prht_pkg;

	// Widths of the item fields.
	localparam int SLOT_W  = 6;
	localparam int KIND_W  = 3;
	localparam int COORD_W = 20;
	localparam int SIZE_W  = 16;

	// Slot numbers carry six bits, so no more than this many slots can be written.
	localparam int MAX_SLOTS = 64;

	// Member kinds; the numeric order is the match priority.
	localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STUD  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LAST  = 3'd5;

	// Stream widths.
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 16;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	// One input item, unpacked from the slave stream.
	typedef struct packed {
		opcode_t                    opcode;
		logic [SLOT_W-1:0]          slot;
		logic [KIND_W-1:0]          member_kind;
		logic [COORD_W-1:0]         corner_u;
		logic [COORD_W-1:0]         corner_z;
		logic [SIZE_W-1:0]          member_length;
		logic [SIZE_W-1:0]          member_width;
		logic [COORD_W-1:0]         query_u;
		logic [COORD_W-1:0]         query_z;
	} item_t;

	// One table entry as stored in the member memory.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COORD_W-1:0] corner_u;
		logic [COORD_W-1:0] corner_z;
		logic [SIZE_W-1:0]  len;
		logic [SIZE_W-1:0]  wid;
	} entry_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic write;
		logic read;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_addr;
		logic pipe_empty;
		logic out_free;
	} status_t;

endpackage

@@ hw/rtl/prht_ctrl.sv @@
module prht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  prht_pkg::opcode_t  in_opcode,
	input  prht_pkg::status_t  status,
	output logic               in_ready,
	output prht_pkg::cmd_t     cmd
);

	prht_pkg::state_t state_q;
	prht_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prht_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			prht_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == prht_pkg::OP_QUERY) begin
						cmd.start = 1'b1;
						state_d   = prht_pkg::ST_SCAN;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			prht_pkg::ST_SCAN: begin
				cmd.read = 1'b1;
				if (status.last_addr) begin
					state_d = prht_pkg::ST_DRAIN;
				end
			end
			prht_pkg::ST_DRAIN: begin
				// The result goes out once the compare pipeline has settled
				// and the output register can take it.
				if (status.pipe_empty && status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = prht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prht_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/prht_datapath.sv @@
module prht_datapath #(
	parameter int ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  prht_pkg::item_t                     item,
	input  prht_pkg::cmd_t                      cmd,
	output prht_pkg::status_t                   status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [prht_pkg::OUT_DATA_W-1:0]     out_data
);

	// Only the slots that a six-bit slot number reaches are stored.
	localparam int DEPTH = (ENTRIES < prht_pkg::MAX_SLOTS) ? ENTRIES : prht_pkg::MAX_SLOTS;
	localparam int AW    = $clog2(DEPTH);

	prht_pkg::entry_t                 mem_q [DEPTH];
	logic [DEPTH-1:0]                 ent_vld_q;
	logic [AW-1:0]                    idx_q;
	logic [prht_pkg::COORD_W-1:0]     qu_q;
	logic [prht_pkg::COORD_W-1:0]     qz_q;

	prht_pkg::entry_t                 ent_s1;
	logic                             ent_vld_s1;
	logic [AW-1:0]                    slot_s1;
	logic                             vld_s1_q;

	logic                             vld_s2_q;
	logic                             hit_s2;
	logic [prht_pkg::KIND_W-1:0]      kind_s2;
	logic [AW-1:0]                    slot_s2;

	logic                             found_q;
	logic [prht_pkg::KIND_W-1:0]      best_kind_q;
	logic [AW-1:0]                    best_slot_q;

	logic                             out_vld_q;
	logic [prht_pkg::OUT_DATA_W-1:0]  out_data_q;

	logic                             wr_in_range;
	logic                             wr_kind_ok;
	logic [prht_pkg::SIZE_W-1:0]      du;
	logic [prht_pkg::SIZE_W-1:0]      dz;
	logic [prht_pkg::COORD_W:0]       upper_u;
	logic [prht_pkg::COORD_W:0]       upper_z;
	logic                             hit_s1;
	logic                             take_best;

	// Write decode: out-of-range slots are dropped, unknown kinds clear.
	assign wr_in_range = 32'({26'd0, item.slot}) < 32'(DEPTH);
	assign wr_kind_ok  = (item.member_kind != prht_pkg::KIND_EMPTY) &&
		(item.member_kind <= prht_pkg::KIND_LAST);

	// Member memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write && wr_in_range && wr_kind_ok) begin
			mem_q[item.slot[AW-1:0]] <= '{
				kind:     item.member_kind,
				corner_u: item.corner_u,
				corner_z: item.corner_z,
				len:      item.member_length,
				wid:      item.member_width
			};
		end
	end

	always_ff @(posedge clk) begin
		ent_s1     <= mem_q[idx_q];
		ent_vld_s1 <= ent_vld_q[idx_q];
		slot_s1    <= idx_q;
	end

	// Entry valid bits; an invalid entry reads as an empty slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (cmd.write && wr_in_range) begin
			ent_vld_q[item.slot[AW-1:0]] <= wr_kind_ok;
		end
	end

	// Scan address counter and the query point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.start) begin
			idx_q <= '0;
		end else if (cmd.read) begin
			idx_q <= AW'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qu_q <= item.query_u;
			qz_q <= item.query_z;
		end
	end

	assign status.last_addr = (idx_q == AW'(DEPTH - 1));

	// Containment test on the entry read last cycle. Studs stand upright,
	// so their length runs along z. Upper bounds carry one extra bit.
	always_comb begin
		if (ent_s1.kind == prht_pkg::KIND_STUD) begin
			du = ent_s1.wid;
			dz = ent_s1.len;
		end else begin
			du = ent_s1.len;
			dz = ent_s1.wid;
		end
		upper_u = {ent_s1.corner_u[prht_pkg::COORD_W-1], ent_s1.corner_u} + {5'd0, du};
		upper_z = {ent_s1.corner_z[prht_pkg::COORD_W-1], ent_s1.corner_z} + {5'd0, dz};
		hit_s1  = ent_vld_s1 &&
			(ent_s1.len != '0) && (ent_s1.wid != '0) &&
			($signed(qu_q) >= $signed(ent_s1.corner_u)) &&
			($signed({qu_q[prht_pkg::COORD_W-1], qu_q}) <= $signed(upper_u)) &&
			($signed(qz_q) >= $signed(ent_s1.corner_z)) &&
			($signed({qz_q[prht_pkg::COORD_W-1], qz_q}) <= $signed(upper_z));
	end

	// Pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q <= 1'b0;
			vld_s2_q <= 1'b0;
		end else begin
			vld_s1_q <= cmd.read;
			vld_s2_q <= vld_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		hit_s2  <= hit_s1;
		kind_s2 <= ent_s1.kind;
		slot_s2 <= slot_s1;
	end

	assign status.pipe_empty = !vld_s1_q && !vld_s2_q;

	// Best match so far: a lower kind wins; within a kind the earlier
	// slot, which the ascending scan sees first, is kept.
	assign take_best = vld_s2_q && hit_s2 && (!found_q || (kind_s2 < best_kind_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			best_kind_q <= prht_pkg::KIND_EMPTY;
			best_slot_q <= '0;
		end else if (cmd.start) begin
			found_q     <= 1'b0;
			best_kind_q <= prht_pkg::KIND_EMPTY;
			best_slot_q <= '0;
		end else if (take_best) begin
			found_q     <= 1'b1;
			best_kind_q <= kind_s2;
			best_slot_q <= slot_s2;
		end
	end

	// Output register; it holds a result until the transfer completes.
	assign status.out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {7'd0, prht_pkg::SLOT_W'(best_slot_q), best_kind_q};
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

endmodule

@@ hw/rtl/priority_rectangle_hit_test_top.sv @@
// Channel   Direction  Ports                      Contents
// s_        in         tvalid tready tdata tuser  write or query item
// m_        out        tvalid tready tdata        hit kind and slot
//
// A write gives no result. A query scans the stored slots (ENTRIES, at
// most 64) one per cycle, and no new item is taken until its result has
// been moved into the output register.
// Reset clears the entry valid bits at once; no clearing pass.
// A result waits in the output register while m_tready is low; the next
// item is still taken, and a later query holds its result until it frees.
`include "priority_rectangle_hit_test_top_assert.svh"

module priority_rectangle_hit_test_top #(
	parameter int ENTRIES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// slot[5:0], member_kind[8:6], corner_u[28:9], corner_z[48:29],
	// member_length[64:49], member_width[80:65], query_u[100:81],
	// query_z[120:101], zero above
	input  logic [prht_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// hit_kind[2:0], hit_slot[8:3], zero above
	output logic [prht_pkg::OUT_DATA_W-1:0]    m_tdata
);

	prht_pkg::item_t   item;
	prht_pkg::cmd_t    cmd;
	prht_pkg::status_t status;

	// Unpack the input item.
	always_comb begin
		item.opcode        = prht_pkg::opcode_t'(s_tuser);
		item.slot          = s_tdata[5:0];
		item.member_kind   = s_tdata[8:6];
		item.corner_u      = s_tdata[28:9];
		item.corner_z      = s_tdata[48:29];
		item.member_length = s_tdata[64:49];
		item.member_width  = s_tdata[80:65];
		item.query_u       = s_tdata[100:81];
		item.query_z       = s_tdata[120:101];
	end

	prht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_opcode (item.opcode),
		.status    (status),
		.in_ready  (s_tready),
		.cmd       (cmd)
	);

	prht_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	// No result can appear in the cycle after an input transfer made while no result is pending.
	`PRHT_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid)
	// A reported kind is always a real member kind or none.
	`PRHT_ASSERT_SAME(a_kind_range, m_tvalid, m_tdata[2:0] <= prht_pkg::KIND_LAST)
	// A miss reports slot zero.
	`PRHT_ASSERT_SAME(a_miss_slot_zero, m_tvalid && (m_tdata[2:0] == prht_pkg::KIND_EMPTY),
		m_tdata[8:3] == 6'd0)

endmodule

@@ tb/sv/priority_rectangle_hit_test_top_tb.sv @@
`timescale 1ns / 1ps

module priority_rectangle_hit_test_top_tb;
	import prht_pkg::*;

	// Member kinds that the package leaves unnamed.
	localparam logic [KIND_W-1:0] KIND_BOTTOM    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TOP       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NOGGIN    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_GENERATED = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNDEF_LO  = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNDEF_HI  = 3'd7;

	localparam logic [COORD_W-1:0] COORD_MIN = 20'h80000;
	localparam logic [COORD_W-1:0] COORD_MAX = 20'h7FFFF;
	localparam logic [SIZE_W-1:0]  SIZE_MAX  = 16'hFFFF;

	localparam int RANDOM_ITEMS = 2000;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int DRAIN_CYCLES = 100;

	// One result as it sits in m_tdata, the kind in the lowest bits.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [KIND_W-1:0] kind;
	} hit_t;

	// Shadow of the member table; works out the hit of every query.
	class hit_tracker;
		logic [KIND_W-1:0]         mem_kind[MAX_SLOTS];
		logic signed [COORD_W-1:0] mem_u[MAX_SLOTS];
		logic signed [COORD_W-1:0] mem_z[MAX_SLOTS];
		logic [SIZE_W-1:0]         mem_len[MAX_SLOTS];
		logic [SIZE_W-1:0]         mem_wid[MAX_SLOTS];
		hit_t                      expected_hits[$];
		int                        mismatches;

		function new();
			for (int i = 0; i < MAX_SLOTS; i++) begin
				mem_kind[i] = KIND_EMPTY;
				mem_u[i] = '0;
				mem_z[i] = '0;
				mem_len[i] = '0;
				mem_wid[i] = '0;
			end
			mismatches = 0;
		endfunction

		// Closed rectangle test at 64-bit precision; studs stand upright.
		function bit covers(int i, longint qu, longint qz);
			longint left, bottom, du, dz;
			if (mem_len[i] == 0 || mem_wid[i] == 0) begin
				return 1'b0;
			end
			left = longint'(mem_u[i]);
			bottom = longint'(mem_z[i]);
			if (mem_kind[i] == KIND_STUD) begin
				du = longint'(mem_wid[i]);
				dz = longint'(mem_len[i]);
			end else begin
				du = longint'(mem_len[i]);
				dz = longint'(mem_wid[i]);
			end
			return qu >= left && qu <= left + du && qz >= bottom && qz <= bottom + dz;
		endfunction

		// Called for every transfer taken on the input side.
		function void note_item(item_t it);
			hit_t   h;
			longint qu, qz;
			int     s;
			if (it.opcode == OP_WRITE) begin
				s = int'(it.slot);
				if (it.member_kind == KIND_EMPTY || it.member_kind > KIND_LAST) begin
					mem_kind[s] = KIND_EMPTY;
					mem_u[s] = '0;
					mem_z[s] = '0;
					mem_len[s] = '0;
					mem_wid[s] = '0;
				end else begin
					mem_kind[s] = it.member_kind;
					mem_u[s] = it.corner_u;
					mem_z[s] = it.corner_z;
					mem_len[s] = it.member_length;
					mem_wid[s] = it.member_width;
				end
				return;
			end
			qu = longint'($signed(it.query_u));
			qz = longint'($signed(it.query_z));
			h = '0;
			// Kind rank first, then lowest slot.
			for (int k = int'(KIND_BOTTOM); k <= int'(KIND_LAST); k++) begin
				for (int i = 0; i < MAX_SLOTS; i++) begin
					if (h.kind == KIND_EMPTY && mem_kind[i] == k && covers(i, qu, qz)) begin
						h.kind = KIND_W'(k);
						h.slot = SLOT_W'(i);
					end
				end
			end
			expected_hits.push_back(h);
		endfunction

		// Called for every transfer taken on the output side.
		function void check_hit(logic [OUT_DATA_W-1:0] data);
			hit_t got, want;
			got = data[KIND_W+SLOT_W-1:0];
			if (expected_hits.size() == 0) begin
				$error("unexpected result: hit_kind %0d hit_slot %0d", got.kind, got.slot);
				mismatches++;
				return;
			end
			want = expected_hits.pop_front();
			if (got.kind != want.kind) begin
				$error("hit_kind: expected %0d, actual %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.slot != want.slot) begin
				$error("hit_slot: expected %0d, actual %0d", want.slot, got.slot);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic hold_request = 1'b0;
	logic hold_done;
	int   hold_left;
	int   ready_mode;
	int   mode_left;

	hit_tracker sb;

	priority_rectangle_hit_test_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// Fully random item; callers overwrite the fields that matter.
	function automatic item_t random_item();
		item_t it;
		it.opcode = opcode_t'($urandom_range(0, 1));
		it.slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
		it.member_kind = KIND_W'($urandom_range(0, 7));
		it.corner_u = COORD_W'($urandom);
		it.corner_z = COORD_W'($urandom);
		it.member_length = SIZE_W'($urandom);
		it.member_width = SIZE_W'($urandom);
		it.query_u = COORD_W'($urandom);
		it.query_z = COORD_W'($urandom);
		return it;
	endfunction

	// Offers one item and holds it until the transfer happens.
	task automatic send_item(input item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= it.opcode;
		s_tdata <= {7'd0, it.query_z, it.query_u, it.member_width, it.member_length,
			it.corner_z, it.corner_u, it.member_kind, it.slot};
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
	endtask

	task automatic send_write(input int slot, input logic [KIND_W-1:0] kind,
		input logic [COORD_W-1:0] cu, input logic [COORD_W-1:0] cz,
		input logic [SIZE_W-1:0] len, input logic [SIZE_W-1:0] wid);
		item_t it;
		it = random_item();
		it.opcode = OP_WRITE;
		it.slot = SLOT_W'(slot);
		it.member_kind = kind;
		it.corner_u = cu;
		it.corner_z = cz;
		it.member_length = len;
		it.member_width = wid;
		send_item(it);
	endtask

	task automatic send_query(input logic [COORD_W-1:0] qu, input logic [COORD_W-1:0] qz);
		item_t it;
		it = random_item();
		it.opcode = OP_QUERY;
		it.query_u = qu;
		it.query_z = qz;
		send_item(it);
	endtask

	// Receiver: shifting stall patterns, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
			ready_mode <= 0;
			mode_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				sb.check_hit(m_tdata);
			end
			if (hold_request && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_OFF_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode <= $urandom_range(0, 2);
					mode_left <= $urandom_range(20, 200);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (ready_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		item_t it;
		int    burst_left;
		int    s;
		int    reach;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extreme corners and sizes, inclusive edges.
		send_query(20'd0, 20'd0);
		send_write(0, KIND_BOTTOM, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX);
		send_write(MAX_SLOTS - 1, KIND_GENERATED, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
		send_query(COORD_MAX, COORD_MAX);
		send_query(COORD_MIN, COORD_MIN);
		send_query(COORD_MIN + 20'd65535, COORD_MIN + 20'd65535);
		send_query(COORD_MIN + 20'd65536, COORD_MIN + 20'd65535);
		// Stud orientation, then kind rank and lowest slot among overlaps.
		send_write(10, KIND_STUD, 20'd100, 20'd200, 16'd300, 16'd40);
		send_query(20'd140, 20'd500);
		send_query(20'd141, 20'd200);
		send_write(5, KIND_NOGGIN, 20'd100, 20'd200, 16'd300, 16'd40);
		send_query(20'd120, 20'd220);
		send_write(20, KIND_TOP, 20'd100, 20'd200, 16'd300, 16'd40);
		send_query(20'd120, 20'd220);
		send_write(2, KIND_TOP, 20'd100, 20'd200, 16'd300, 16'd40);
		send_query(20'd120, 20'd220);
		// Clears by unknown kind and by empty kind, then degenerate members.
		send_write(2, KIND_UNDEF_LO, 20'd100, 20'd200, 16'd300, 16'd40);
		send_query(20'd120, 20'd220);
		send_write(20, KIND_EMPTY, 20'd100, 20'd200, 16'd300, 16'd40);
		send_query(20'd120, 20'd220);
		send_write(10, KIND_STUD, 20'd100, 20'd200, 16'd0, 16'd40);
		send_query(20'd120, 20'd220);
		send_write(5, KIND_NOGGIN, 20'd100, 20'd200, 16'd300, 16'd0);
		send_query(20'd120, 20'd220);
		send_write(30, KIND_UNDEF_HI, 20'd0, 20'd0, 16'd10, 16'd10);

		// Random: members clustered near the origin so that they overlap,
		// queries mostly aimed near a stored member.
		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 5) begin
				hold_request <= 1'b1;
			end
			if (n == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sb.expected_hits.size() != 0);
			end else if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
			it = random_item();
			if ($urandom_range(0, 99) < 45) begin
				it.opcode = OP_WRITE;
				case ($urandom_range(0, 9))
					0: it.member_kind = KIND_EMPTY;
					1: it.member_kind = KIND_W'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
					default: it.member_kind = KIND_W'($urandom_range(KIND_BOTTOM, KIND_LAST));
				endcase
				if ($urandom_range(0, 99) < 85) begin
					it.corner_u = COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
					it.corner_z = COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
					it.member_length = ($urandom_range(0, 15) == 0) ? SIZE_W'(0) :
						SIZE_W'($urandom_range(1, 600));
					it.member_width = ($urandom_range(0, 15) == 0) ? SIZE_W'(0) :
						SIZE_W'($urandom_range(1, 600));
				end
			end else begin
				it.opcode = OP_QUERY;
				if ($urandom_range(0, 99) < 70) begin
					s = $urandom_range(0, MAX_SLOTS - 1);
					reach = (sb.mem_len[s] > sb.mem_wid[s]) ? int'(sb.mem_len[s]) :
						int'(sb.mem_wid[s]);
					it.query_u = sb.mem_u[s] + COORD_W'($urandom_range(0, reach + 4)) - COORD_W'(2);
					it.query_z = sb.mem_z[s] + COORD_W'($urandom_range(0, reach + 4)) - COORD_W'(2);
				end else if ($urandom_range(0, 1) == 0) begin
					it.query_u = COORD_W'($urandom_range(0, 5000)) - COORD_W'(2500);
					it.query_z = COORD_W'($urandom_range(0, 5000)) - COORD_W'(2500);
				end
			end
			send_item(it);
		end
		s_tvalid <= 1'b0;

		// Let every result come out, then a little longer for strays.
		while (sb.expected_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
